/* rtl/core/bdm_pkg.sv */
// Shared types, constants and helper functions for the Bayer demosaicing core.
`timescale 1ns / 1ps
`default_nettype none

package bdm_pkg;

  localparam int PIX_W            = 8;
  localparam int WIDTH_FIELD_W    = 11;
  localparam int HEIGHT_FIELD_W   = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_INDEX_W      = 2;
  localparam int ROW_W            = 13;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int MIN_SIZE         = 3;
  localparam int RESET_WIDTH      = 640;
  localparam int RESET_HEIGHT     = 480;
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int STORED_LINES_DEF = 5;
  localparam int ARITH_W          = 12;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_METHOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

  // Item kinds on the input channel.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // 5x5 window: first index is the row tap (0 newest row), second the column tap (0 newest).
  typedef logic [4:0][4:0][PIX_W-1:0] win_t;

  // Position of the pixel being interpolated, reduced to what the border logic needs.
  typedef struct packed {
    logic mhc;
    logic row_odd;
    logic col_odd;
    logic r_f0;
    logic r_f1;
    logic r_l0;
    logic r_l1;
    logic c_f0;
    logic c_f1;
    logic c_l0;
    logic c_l1;
  } site_t;

  // Window tap for offset d from the centre, with the border mirrored without repeating
  // the edge sample.
  function automatic logic [2:0] tap_idx(input logic mhc, input logic signed [2:0] d,
                                         input logic f0, input logic f1,
                                         input logic l0, input logic l1);
    logic signed [3:0] de;
    logic signed [3:0] t;
    logic [2:0] res;
    de = 4'(d);
    if (d == -3'sd2) begin
      if (f0) de = 4'sd2;
      else if (f1) de = 4'sd0;
    end else if (d == -3'sd1) begin
      if (f0) de = 4'sd1;
    end else if (d == 3'sd1) begin
      if (l0) de = -4'sd1;
    end else if (d == 3'sd2) begin
      if (l0) de = -4'sd2;
      else if (l1) de = 4'sd0;
    end
    t = (mhc ? 4'sd2 : 4'sd1) - de;
    if (t < 4'sd0 || t > 4'sd4) res = 3'd0;
    else res = 3'(t);
    return res;
  endfunction

  // Difference of the positive and negative kernel parts, floored /8 and clamped to 0..255.
  function automatic logic [PIX_W-1:0] fin8(input logic [ARITH_W-1:0] pos,
                                            input logic [ARITH_W-1:0] neg);
    logic [ARITH_W-1:0] diff;
    logic [ARITH_W-1:0] q;
    logic [PIX_W-1:0] res;
    diff = pos - neg;
    q = diff >> 3;
    if (pos < neg) res = '0;
    else if (q > ARITH_W'(255)) res = 8'd255;
    else res = q[PIX_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bdm_interp.sv */
// Border selection and bilinear / Malvar-He-Cutler interpolation of one window.
`timescale 1ns / 1ps
`default_nettype none

module bdm_interp (
  input  wire bdm_pkg::win_t                 win,
  input  wire bdm_pkg::site_t                site,
  output logic [bdm_pkg::PIX_W-1:0]          red,
  output logic [bdm_pkg::PIX_W-1:0]          green,
  output logic [bdm_pkg::PIX_W-1:0]          blue
);

  localparam int AW = bdm_pkg::ARITH_W;

  logic [2:0] rt [5];
  logic [2:0] ct [5];

  logic [7:0] c_px, l_px, r_px, u_px, d_px, ul_px, ur_px, dl_px, dr_px;
  logic [7:0] l2_px, r2_px, u2_px, d2_px;
  logic [AW-1:0] s_lr, s_ud, s_dg, s_h2, s_v2, s_far, s_c;
  logic [7:0] across, updown, cross_v, diag;
  logic green_site;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      rt[k] = bdm_pkg::tap_idx(site.mhc, 3'(k - 2), site.r_f0, site.r_f1, site.r_l0, site.r_l1);
      ct[k] = bdm_pkg::tap_idx(site.mhc, 3'(k - 2), site.c_f0, site.c_f1, site.c_l0, site.c_l1);
    end
  end

  always_comb begin
    c_px  = win[rt[2]][ct[2]];
    l_px  = win[rt[2]][ct[1]];
    r_px  = win[rt[2]][ct[3]];
    u_px  = win[rt[1]][ct[2]];
    d_px  = win[rt[3]][ct[2]];
    ul_px = win[rt[1]][ct[1]];
    ur_px = win[rt[1]][ct[3]];
    dl_px = win[rt[3]][ct[1]];
    dr_px = win[rt[3]][ct[3]];
    l2_px = win[rt[2]][ct[0]];
    r2_px = win[rt[2]][ct[4]];
    u2_px = win[rt[0]][ct[2]];
    d2_px = win[rt[4]][ct[2]];

    s_c   = AW'(c_px);
    s_lr  = AW'(l_px) + AW'(r_px);
    s_ud  = AW'(u_px) + AW'(d_px);
    s_dg  = AW'(ul_px) + AW'(ur_px) + AW'(dl_px) + AW'(dr_px);
    s_h2  = AW'(l2_px) + AW'(r2_px);
    s_v2  = AW'(u2_px) + AW'(d2_px);
    s_far = s_h2 + s_v2;

    if (site.mhc) begin
      across  = bdm_pkg::fin8((s_lr << 2) + s_c * AW'(5) + (s_v2 >> 1), s_dg + s_h2);
      updown  = bdm_pkg::fin8((s_ud << 2) + s_c * AW'(5) + (s_h2 >> 1), s_dg + s_v2);
      cross_v = bdm_pkg::fin8(((s_lr + s_ud) << 1) + (s_c << 2), s_far);
      diag    = bdm_pkg::fin8((s_dg << 1) + s_c * AW'(6), (s_far * AW'(3)) >> 1);
    end else begin
      across  = 8'(s_lr >> 1);
      updown  = 8'(s_ud >> 1);
      cross_v = 8'((s_lr + s_ud) >> 2);
      diag    = 8'(s_dg >> 2);
    end

    // GRBG: green where row and column parity agree, red on even rows, blue on odd rows.
    green_site = (site.row_odd == site.col_odd);
    if (green_site) begin
      green = c_px;
      if (!site.row_odd) begin
        red  = across;
        blue = updown;
      end else begin
        blue = across;
        red  = updown;
      end
    end else if (!site.row_odd) begin
      red   = c_px;
      green = cross_v;
      blue  = diag;
    end else begin
      blue  = c_px;
      green = cross_v;
      red   = diag;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bayer_demosaic_bilinear_mhc_core.sv */
// Top level of the GRBG Bayer demosaicing core: sample store, line buffers, window and output.
// Usage:
//   Raw samples enter in raster order on the in_ channel (valid/ready); in_op marks a flush
//   transaction that carries no sample and only pushes the frame end through. One RGB pixel
//   leaves per position on the out_ channel (valid/ready); out_frame_end marks the last one.
//   Pixel k of a frame leaves with input transaction k+2W+2 (Malvar-He-Cutler) or k+W+1
//   (bilinear), so 2W+2 or W+1 flush transactions drain the end of a frame.
//   Once its causing transaction is accepted, a pixel moves from the sample store and line
//   buffer reads (stage 1) to the window shift (stage 2) and then to the interpolation result
//   in the output register; a stalled receiver can hold it at any of these.
//   Throughput is one transaction per clock unless the receiver stalls; every stage is a
//   single pass through short logic. A stalled receiver holds the output register and backs
//   up through the two internal stages, so in_ready falls only once those are full.
//   Reset (rst_n low at a clock edge) selects bilinear at 640x480 and restarts the frame; the
//   sample store needs no clearing pass. Configuration writes to method, width or height also
//   restart the frame; the user must make them only while the core is idle (unenforced).
//   The sample store is a ring of STORED_LINES*MAX_WIDTH entries; MHC needs it to hold 4W+5.
`timescale 1ns / 1ps
`default_nettype none

module bayer_demosaic_bilinear_mhc_core #(
  parameter int MAX_WIDTH    = bdm_pkg::MAX_WIDTH_DEF,
  parameter int STORED_LINES = bdm_pkg::STORED_LINES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_op,
  input  wire  [bdm_pkg::PIX_W-1:0]           in_raw_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [bdm_pkg::PIX_W-1:0]           out_red,
  output logic [bdm_pkg::PIX_W-1:0]           out_green,
  output logic [bdm_pkg::PIX_W-1:0]           out_blue,
  output logic                                out_frame_end,
  input  wire                                 cfg_we,
  input  wire  [bdm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [bdm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RING_DEPTH = STORED_LINES * MAX_WIDTH;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int WF_W       = bdm_pkg::WIDTH_FIELD_W;
  localparam int HF_W       = bdm_pkg::HEIGHT_FIELD_W;
  localparam int ROW_W      = bdm_pkg::ROW_W;
  localparam int PIX_W      = bdm_pkg::PIX_W;
  localparam int RESET_W    = (bdm_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                 : bdm_pkg::RESET_WIDTH;

  // Configuration
  logic             method_r;
  logic [WF_W-1:0]  width_r;
  logic [HF_W-1:0]  height_r;
  logic [WF_W-1:0]  width_nxt;
  logic [HF_W-1:0]  height_nxt;

  // Position counters
  logic [COL_W-1:0]   in_col_r, out_col_r;
  logic [ROW_W-1:0]   in_row_r, out_row_r;
  logic [RING_AW-1:0] ring_ptr_r;

  logic acc, px_write, has_out, fend;
  logic in_last_col, out_last_col, out_last_row;
  bdm_pkg::site_t site0;

  // Stage 1: store reads
  logic               s1_valid_r, s1_pix_r, s1_has_r, s1_fend_r;
  logic [PIX_W-1:0]   s1_val_r;
  logic [COL_W-1:0]   s1_col_r;
  bdm_pkg::site_t     s1_site_r;
  logic [PIX_W-1:0]   ring_q_r;
  logic [3:0][PIX_W-1:0] line_q_r;
  logic [PIX_W-1:0]   s1_px;

  // Stage 2: window
  logic               s2_valid_r, s2_has_r, s2_fend_r;
  bdm_pkg::site_t     s2_site_r;
  bdm_pkg::win_t      win_r;

  logic adv1, adv2, s2_free, out_free;

  logic [PIX_W-1:0] ip_red, ip_green, ip_blue;
  logic             out_valid_r, out_frame_end_r;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;

  logic [PIX_W-1:0]        ring_mem [RING_DEPTH];
  logic [3:0][PIX_W-1:0]   line_mem [MAX_WIDTH];

  // Handshake chain from the output register back to the input.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    adv2     = s2_valid_r && (!s2_has_r || out_free);
    s2_free  = !s2_valid_r || adv2;
    adv1     = s1_valid_r && s2_free;
    in_ready = !s1_valid_r || adv1;
    acc      = in_valid && in_ready;
  end

  // Saturate written sizes into their legal ranges.
  always_comb begin
    width_nxt = cfg_wdata[WF_W-1:0];
    if (32'(cfg_wdata[WF_W-1:0]) < bdm_pkg::MIN_SIZE) width_nxt = WF_W'(bdm_pkg::MIN_SIZE);
    else if (32'(cfg_wdata[WF_W-1:0]) > MAX_WIDTH) width_nxt = WF_W'(MAX_WIDTH);
    height_nxt = cfg_wdata[HF_W-1:0];
    if (32'(cfg_wdata[HF_W-1:0]) < bdm_pkg::MIN_SIZE) height_nxt = HF_W'(bdm_pkg::MIN_SIZE);
    else if (32'(cfg_wdata[HF_W-1:0]) > bdm_pkg::HEIGHT_LIMIT)
      height_nxt = HF_W'(bdm_pkg::HEIGHT_LIMIT);
  end

  always_comb begin
    in_last_col  = 32'(in_col_r) == 32'(width_r) - 32'd1;
    out_last_col = 32'(out_col_r) == 32'(width_r) - 32'd1;
    out_last_row = 32'(out_row_r) == 32'(height_r) - 32'd1;
    px_write     = (in_op == bdm_pkg::OP_PIXEL) && (32'(in_row_r) < 32'(height_r));
    // Output starts once the newest sample lies two (MHC) or one (bilinear) rows and columns
    // past the pixel it completes.
    if (method_r) begin
      has_out = (in_row_r > ROW_W'(2)) || (in_row_r == ROW_W'(2) && 32'(in_col_r) >= 32'd2);
    end else begin
      has_out = (in_row_r > ROW_W'(1)) || (in_row_r == ROW_W'(1) && 32'(in_col_r) >= 32'd1);
    end
    fend = has_out && out_last_col && out_last_row;

    site0.mhc     = method_r;
    site0.row_odd = out_row_r[0];
    site0.col_odd = out_col_r[0];
    site0.r_f0    = out_row_r == '0;
    site0.r_f1    = out_row_r == ROW_W'(1);
    site0.r_l0    = out_last_row;
    site0.r_l1    = 32'(out_row_r) == 32'(height_r) - 32'd2;
    site0.c_f0    = out_col_r == '0;
    site0.c_f1    = 32'(out_col_r) == 32'd1;
    site0.c_l0    = out_last_col;
    site0.c_l1    = 32'(out_col_r) == 32'(width_r) - 32'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r   <= 1'b0;
      width_r    <= WF_W'(RESET_W);
      height_r   <= HF_W'(bdm_pkg::RESET_HEIGHT);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      ring_ptr_r <= '0;
    end else if (cfg_we && (cfg_index == bdm_pkg::CFG_METHOD ||
                            cfg_index == bdm_pkg::CFG_WIDTH ||
                            cfg_index == bdm_pkg::CFG_HEIGHT)) begin
      case (cfg_index)
        bdm_pkg::CFG_METHOD: method_r <= cfg_wdata[0];
        bdm_pkg::CFG_WIDTH:  width_r  <= width_nxt;
        bdm_pkg::CFG_HEIGHT: height_r <= height_nxt;
        default: method_r <= method_r;
      endcase
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      ring_ptr_r <= '0;
    end else if (acc) begin
      if (fend) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        ring_ptr_r <= '0;
      end else begin
        if (in_last_col) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
        if (has_out) begin
          if (out_last_col) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
        if (32'(ring_ptr_r) == RING_DEPTH - 1) ring_ptr_r <= '0;
        else ring_ptr_r <= ring_ptr_r + RING_AW'(1);
      end
    end
  end

  // Sample store: the old entry is read while the new sample is written, so a flush keeps
  // whatever the position held before.
  always_ff @(posedge clk) begin
    if (acc) begin
      ring_q_r <= ring_mem[ring_ptr_r];
      if (px_write) ring_mem[ring_ptr_r] <= in_raw_value;
    end
  end

  // Line buffers: one word per column holds the four rows above the newest sample.
  always_ff @(posedge clk) begin
    if (acc) line_q_r <= line_mem[in_col_r];
    if (adv1) line_mem[s1_col_r] <= {line_q_r[2:0], s1_px};
  end

  assign s1_px = s1_pix_r ? s1_val_r : ring_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv1) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= px_write;
      s1_val_r  <= in_raw_value;
      s1_has_r  <= has_out;
      s1_fend_r <= fend;
      s1_site_r <= site0;
      s1_col_r  <= in_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv1) begin
      s2_valid_r <= 1'b1;
    end else if (adv2) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_has_r  <= s1_has_r;
      s2_fend_r <= s1_fend_r;
      s2_site_r <= s1_site_r;
      win_r[0][0] <= s1_px;
      for (int i = 1; i < 5; i++) begin
        win_r[i][0] <= line_q_r[i-1];
      end
      for (int i = 0; i < 5; i++) begin
        for (int j = 1; j < 5; j++) begin
          win_r[i][j] <= win_r[i][j-1];
        end
      end
    end
  end

  bdm_interp u_interp (
    .win   (win_r),
    .site  (s2_site_r),
    .red   (ip_red),
    .green (ip_green),
    .blue  (ip_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2 && s2_has_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_has_r) begin
      out_red_r       <= ip_red;
      out_green_r     <= ip_green;
      out_blue_r      <= ip_blue;
      out_frame_end_r <= s2_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_frame_end = out_frame_end_r;

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(in_col_r) < 32'(width_r))
    else $error("input column counter beyond frame width");

  a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(out_col_r) < 32'(width_r)) && (32'(out_row_r) < 32'(height_r)))
    else $error("output position beyond frame");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ring_ptr_r) < RING_DEPTH)
    else $error("sample store pointer beyond its depth");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && s2_has_r |=> out_valid_r)
    else $error("interpolated pixel did not reach the output register");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && fend && !cfg_we |=> (in_row_r == '0) && (out_row_r == '0) && (ring_ptr_r == '0))
    else $error("frame end did not restart the position counters");

endmodule

`default_nettype wire

/* dv/tb_bayer_demosaic_bilinear_mhc_core.sv */
// Self-checking testbench for the GRBG Bayer demosaicing core in both interpolation methods.
`timescale 1ns / 1ps

module tb_bayer_demosaic_bilinear_mhc_core;

  localparam int RING_DEPTH = bdm_pkg::STORED_LINES_DEF * bdm_pkg::MAX_WIDTH_DEF;
  localparam logic [bdm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned NO_CAP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_pix_t;

  typedef struct packed {
    logic       op;
    logic [7:0] raw;
    logic       typed;
    rgb_pix_t   pix;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_op;
  logic [7:0] in_raw_value;
  logic out_ready;
  logic cfg_we;
  logic [bdm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bdm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  wire in_ready;
  wire out_valid;
  wire [7:0] out_red;
  wire [7:0] out_green;
  wire [7:0] out_blue;
  wire out_frame_end;

  bayer_demosaic_bilinear_mhc_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_raw_value(in_raw_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_frame_end(out_frame_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the core's state.
  logic [7:0] sample_ring [RING_DEPTH];
  bit         ring_written [RING_DEPTH];
  int unsigned in_pos;
  int unsigned out_pos;
  bit          use_mhc;
  bit [10:0]   width_reg;
  bit [12:0]   height_reg;

  rgb_pix_t pending_pixels[$];
  int       error_count;
  int       random_items;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int frame_w();
    return (width_reg < 3) ? 3 : (width_reg > bdm_pkg::MAX_WIDTH_DEF) ? bdm_pkg::MAX_WIDTH_DEF
                                                                       : int'(width_reg);
  endfunction

  function automatic int frame_h();
    return (height_reg < 3) ? 3 : (height_reg > bdm_pkg::HEIGHT_LIMIT) ? bdm_pkg::HEIGHT_LIMIT
                                                                        : int'(height_reg);
  endfunction

  function automatic int fold(int v, int n);
    int m;
    m = (v < 0) ? -v : v;
    if (m >= n) m = 2 * n - 2 - m;
    if (m < 0) m = 0;
    if (m >= n) m = n - 1;
    return m;
  endfunction

  function automatic int sample_at(int r, int c, int w, int h);
    return int'(sample_ring[(fold(r, h) * w + fold(c, w)) % RING_DEPTH]);
  endfunction

  function automatic int floor8(int v);
    if (v < 0) return 0;
    return (v / 8 > 255) ? 255 : v / 8;
  endfunction

  function automatic rgb_pix_t interpolate(int r, int c, int w, int h);
    int ctr, lf, rt, up, dn, dg, lf2, rt2, up2, dn2, far4;
    int across, updown, cross_v, diag;
    rgb_pix_t p;
    ctr = sample_at(r, c, w, h);
    lf  = sample_at(r, c - 1, w, h);
    rt  = sample_at(r, c + 1, w, h);
    up  = sample_at(r - 1, c, w, h);
    dn  = sample_at(r + 1, c, w, h);
    dg  = sample_at(r - 1, c - 1, w, h) + sample_at(r - 1, c + 1, w, h)
        + sample_at(r + 1, c - 1, w, h) + sample_at(r + 1, c + 1, w, h);
    if (!use_mhc) begin
      across  = (lf + rt) / 2;
      updown  = (up + dn) / 2;
      cross_v = (lf + rt + up + dn) / 4;
      diag    = dg / 4;
    end else begin
      lf2  = sample_at(r, c - 2, w, h);
      rt2  = sample_at(r, c + 2, w, h);
      up2  = sample_at(r - 2, c, w, h);
      dn2  = sample_at(r + 2, c, w, h);
      far4 = lf2 + rt2 + up2 + dn2;
      across  = floor8(4 * (lf + rt) + 5 * ctr - dg - (lf2 + rt2) + (up2 + dn2) / 2);
      updown  = floor8(4 * (up + dn) + 5 * ctr - dg - (up2 + dn2) + (lf2 + rt2) / 2);
      cross_v = floor8(2 * (lf + rt + up + dn) + 4 * ctr - far4);
      diag    = floor8(2 * dg + 6 * ctr - far4 * 3 / 2);
    end
    p.frame_end = 1'b0;
    if (((r + c) & 1) == 0) begin
      p.green = 8'(ctr);
      if ((r & 1) == 0) begin
        p.red = 8'(across);
        p.blue = 8'(updown);
      end else begin
        p.blue = 8'(across);
        p.red = 8'(updown);
      end
    end else if ((r & 1) == 0) begin
      p.red = 8'(ctr);
      p.green = 8'(cross_v);
      p.blue = 8'(diag);
    end else begin
      p.blue = 8'(ctr);
      p.green = 8'(cross_v);
      p.red = 8'(diag);
    end
    return p;
  endfunction

  // Advances the mirrored state by one input transaction; returns 1 when a pixel leaves.
  function automatic bit demosaic_step(logic op, logic [7:0] raw, output rgb_pix_t p);
    int w, h;
    int unsigned total, lag;
    w = frame_w();
    h = frame_h();
    total = w * h;
    lag = use_mhc ? 2 * w + 2 : w + 1;
    p = '0;
    if (op == bdm_pkg::OP_PIXEL && in_pos < total) begin
      sample_ring[in_pos % RING_DEPTH] = raw;
      ring_written[in_pos % RING_DEPTH] = 1'b1;
    end
    if (in_pos < lag || out_pos >= total) begin
      in_pos++;
      return 1'b0;
    end
    p = interpolate(out_pos / w, out_pos % w, w, h);
    if (out_pos + 1 >= total) begin
      p.frame_end = 1'b1;
      in_pos = 0;
      out_pos = 0;
    end else begin
      in_pos++;
      out_pos++;
    end
    return 1'b1;
  endfunction

  // Random wait before an item or result; quiet stretches have no idling at all on either side.
  function automatic int draw_wait();
    if (((random_items / 150) % 4) == 3) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_item(logic op, logic [7:0] raw, bit typed, rgb_pix_t typed_pix);
    int gap;
    rgb_pix_t p;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_raw_value <= raw;
    do @(posedge clk); while (!in_ready);
    if (demosaic_step(op, raw, p)) pending_pixels.push_back(typed ? typed_pix : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [bdm_pkg::CFG_INDEX_W-1:0] idx,
                           logic [bdm_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdm_pkg::CFG_METHOD: use_mhc = data[0];
      bdm_pkg::CFG_WIDTH:  width_reg = data[10:0];
      bdm_pkg::CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    if (idx == bdm_pkg::CFG_METHOD || idx == bdm_pkg::CFG_WIDTH ||
        idx == bdm_pkg::CFG_HEIGHT) begin
      in_pos = 0;
      out_pos = 0;
    end
  endtask

  function automatic logic [7:0] draw_sample();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom);
  endfunction

  // One frame, optionally cut short or capped, followed by the transactions that push its
  // end out. Flushes inside the frame only land on positions that already hold a sample.
  task automatic run_frame(bit cut_short, int unsigned cap);
    int unsigned total, lag, stop_at;
    logic op;
    total = frame_w() * frame_h();
    lag = use_mhc ? 2 * frame_w() + 2 : frame_w() + 1;
    stop_at = cut_short ? $urandom_range(1, total + lag - 1) : total + lag;
    if (stop_at > cap) stop_at = cap;
    for (int unsigned t = 0; t < stop_at; t++) begin
      if (in_pos < total)
        op = ($urandom_range(0, 15) == 0 && ring_written[in_pos % RING_DEPTH])
             ? bdm_pkg::OP_FLUSH : bdm_pkg::OP_PIXEL;
      else
        op = $urandom_range(0, 1) ? bdm_pkg::OP_FLUSH : bdm_pkg::OP_PIXEL;
      send_item(op, draw_sample(), 1'b0, '0);
      random_items++;
    end
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clk);
    end
  endtask

  task automatic configure(bit m, logic [bdm_pkg::CFG_DATA_W-1:0] w,
                           logic [bdm_pkg::CFG_DATA_W-1:0] h);
    write_reg(bdm_pkg::CFG_METHOD, {12'($urandom), m});
    write_reg(bdm_pkg::CFG_WIDTH, w);
    write_reg(bdm_pkg::CFG_HEIGHT, h);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 13'($urandom));
  endtask

  // Sink: draws a stall before each result and checks every pixel in order.
  initial begin
    int stall;
    rgb_pix_t want;
    out_ready = 1'b0;
    stall = $urandom_range(0, 12);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_red);
            error_count++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_green);
            error_count++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_blue);
            error_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
            error_count++;
          end
        end
        stall = draw_wait();
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t plan [26];
    rgb_pix_t flat;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = bdm_pkg::OP_PIXEL;
    in_raw_value = '0;
    cfg_we = 1'b0;
    cfg_index = bdm_pkg::CFG_METHOD;
    cfg_wdata = '0;
    error_count = 0;
    random_items = 0;
    in_pos = 0;
    out_pos = 0;
    use_mhc = 1'b0;
    width_reg = 11'(bdm_pkg::RESET_WIDTH);
    height_reg = 13'(bdm_pkg::RESET_HEIGHT);
    foreach (ring_written[i]) begin
      ring_written[i] = 1'b0;
      sample_ring[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two flat 3x3 bilinear frames, all 255 then all 0; a flat image comes back unchanged.
    // Drain rows mix flush ticks with pixels past the frame, which the core ignores.
    for (int f = 0; f < 2; f++) begin
      flat = {{3{(f == 0) ? 8'd255 : 8'd0}}, 1'b0};
      for (int i = 0; i < 13; i++) begin
        plan[f * 13 + i].op = (i >= 9 && i[0]) ? bdm_pkg::OP_FLUSH : bdm_pkg::OP_PIXEL;
        plan[f * 13 + i].raw = (i < 9) ? flat.red : 8'($urandom);
        plan[f * 13 + i].typed = (i >= 4);
        plan[f * 13 + i].pix = flat;
        plan[f * 13 + i].pix.frame_end = (i == 12);
      end
    end
    write_reg(bdm_pkg::CFG_WIDTH, 13'd3);
    write_reg(bdm_pkg::CFG_HEIGHT, 13'd3);
    foreach (plan[i]) send_item(plan[i].op, plan[i].raw, plan[i].typed, plan[i].pix);

    // Size extremes, including values outside the legal range that saturate. The widest and
    // tallest frames are only run through their first rows.
    configure(1'b0, 13'h1FFF, 13'd2);
    run_frame(1'b0, 1060);
    configure(1'b1, 13'd2, 13'h1FFF);
    run_frame(1'b0, 120);
    configure(1'b1, 13'd2, 13'd2);
    run_frame(1'b0, NO_CAP);
    configure(1'b0, 13'd3, 13'd4096);
    run_frame(1'b1, 60);

    random_items = 0;
    while (random_items < 150) begin
      configure(1'($urandom_range(0, 1)), 13'($urandom_range(3, 10)),
                13'($urandom_range(3, 6)));
      for (int n = $urandom_range(1, 3); n > 0; n--)
        run_frame($urandom_range(0, 5) == 0, NO_CAP);
    end
    drain();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
